### hw/rtl/ambient_light_day_night_detector_top_macros.svh
// Assertion macros shared by the detector RTL.
`ifndef AMBIENT_LIGHT_DAY_NIGHT_DETECTOR_TOP_MACROS_SVH
`define AMBIENT_LIGHT_DAY_NIGHT_DETECTOR_TOP_MACROS_SVH

// Checked at every rising edge of aclk outside reset.
`define ALDND_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every rising edge of aclk, reset included.
`define ALDND_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### hw/rtl/aldnd_pkg.sv
package aldnd_pkg;

    localparam int COUNT_W = 16;
    localparam int AVG_W   = 20;
    localparam int TOTAL_W = 32;
    localparam int LIMIT_W = 4;
    localparam int HELD_OUT_W = 3;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [COUNT_W-1:0] NIGHT_LEVEL_RST = 16'd40;
    localparam logic [COUNT_W-1:0] DAY_LEVEL_RST   = 16'd70;
    localparam logic [LIMIT_W-1:0] ERROR_LIMIT_RST = 4'd3;

    typedef enum logic [1:0] {
        REG_NIGHT_LEVEL = 2'd0,
        REG_DAY_LEVEL   = 2'd1,
        REG_ERROR_LIMIT = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_CMP,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

### hw/rtl/aldnd_ram.sv
module aldnd_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 5,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/aldnd_sdiv.sv
`include "ambient_light_day_night_detector_top_macros.svh"

module aldnd_sdiv #(
    parameter int DIVIDEND_W = 26,
    parameter int DIVISOR_W  = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    always_comb begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start && !busy_reg) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DIVIDEND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    `ALDND_ASSERT(a_start_when_free, start |-> !busy_reg, "Divider started while busy.")
    `ALDND_ASSERT(a_rem_below_divisor, (busy_reg && dvs_reg != '0) |-> rem_reg < dvs_reg,
        "Divider remainder reached the divisor.")
    `ALDND_ASSERT(a_done_ends_run, done_reg |-> ($past(busy_reg) && !busy_reg),
        "Divider finished without a run.")

endmodule

### hw/rtl/ambient_light_day_night_detector_top.sv
// Ambient light day/night detector.
// Input beats carry one sensor poll: s_read_ok and s_raw_count (lux = count / 1.2).
// Each accepted beat produces exactly one result beat on the m_ channel, giving the
// window average lux with 4 fractional bits, the day/night flag with hysteresis,
// the error run, the reset request and the good and failed poll totals.
// Items are handled one at a time. A failed poll goes from acceptance straight to
// the result stage, ST_OUT; a good poll passes through ST_SUM, ST_MUL, ST_CMP and
// ST_DIV first, where the bit-serial divider forms the average, one quotient bit a cycle.
// The next beat is taken once the result has been loaded into the output register.
// The window lives in a small RAM with a registered read, one access per stage.
// The result waits in an output register; a new beat is accepted while it waits,
// and only the loading of the next result stalls until m_ready has taken it.
// Thresholds and the error limit must be written over APB only while idle (the block
// itself does not enforce it); pready is always high, reads return the register value.
// After the synchronous active-low reset the window is empty, the classification
// is day, all counts are zero and the registers hold 40, 70 and 3.
module ambient_light_day_night_detector_top #(
    parameter int WINDOW_SAMPLES = 5
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [aldnd_pkg::PADDR_W-1:0]  paddr,
    input  logic [aldnd_pkg::PDATA_W-1:0]  pwdata,
    output logic [aldnd_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_read_ok,
    input  logic [aldnd_pkg::COUNT_W-1:0]  s_raw_count,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [aldnd_pkg::AVG_W-1:0]    m_avg_lux_q4,
    output logic                           m_night_state,
    output logic                           m_night_changed,
    output logic                           m_reset_request,
    output logic [aldnd_pkg::HELD_OUT_W-1:0] m_samples_held,
    output logic [aldnd_pkg::LIMIT_W-1:0]  m_error_run,
    output logic [aldnd_pkg::TOTAL_W-1:0]  m_good_total,
    output logic [aldnd_pkg::TOTAL_W-1:0]  m_bad_total
);

    import aldnd_pkg::*;

    `include "ambient_light_day_night_detector_top_macros.svh"

    localparam int HELD_W  = $clog2(WINDOW_SAMPLES + 1);
    localparam int SLOT_W  = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
    localparam int SUM_W   = COUNT_W + HELD_W;
    localparam int H6_W    = HELD_W + 3;
    localparam int CMP_W   = SUM_W + 3;
    localparam int DIV_W   = SUM_W + 7;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [HELD_W-1:0]  held_reg, held_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               night_reg, night_next;
    logic               changed_reg, changed_next;
    logic               request_reg, request_next;
    logic [LIMIT_W-1:0] fail_run_reg, fail_run_next;
    logic [TOTAL_W-1:0] good_reg, good_next;
    logic [TOTAL_W-1:0] bad_reg, bad_next;
    logic [AVG_W-1:0]   avg_reg, avg_next;
    logic [CMP_W-1:0]   prod_reg, prod_next;

    logic [COUNT_W-1:0] night_level_reg, day_level_reg;
    logic [LIMIT_W-1:0] error_limit_reg;

    logic               m_valid_reg, m_valid_next;
    logic [AVG_W-1:0]   m_avg_reg;
    logic               m_night_state_reg, m_changed_reg, m_request_reg;
    logic [HELD_OUT_W-1:0] m_held_reg;
    logic [LIMIT_W-1:0] m_error_run_reg;
    logic [TOTAL_W-1:0] m_good_reg, m_bad_reg;
    logic               load_out;

    logic               ram_wr_en, ram_rd_en;
    logic [COUNT_W-1:0] ram_rd_data;

    logic               div_start, div_busy, div_done;
    logic [DIV_W-1:0]   div_dividend, div_quotient;

    logic               full;
    logic [H6_W-1:0]    held6;
    logic [CMP_W-1:0]   lhs;
    logic [COUNT_W-1:0] level_sel;
    logic [LIMIT_W-1:0] fail_inc;
    logic [HELD_W+HELD_OUT_W-1:0] held_ext;
    logic               cfg_wr;
    reg_index_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_index_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            night_level_reg <= NIGHT_LEVEL_RST;
            day_level_reg   <= DAY_LEVEL_RST;
            error_limit_reg <= ERROR_LIMIT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_NIGHT_LEVEL: night_level_reg <= pwdata[COUNT_W-1:0];
                REG_DAY_LEVEL:   day_level_reg   <= pwdata[COUNT_W-1:0];
                REG_ERROR_LIMIT: error_limit_reg <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_NIGHT_LEVEL: prdata = PDATA_W'(night_level_reg);
            REG_DAY_LEVEL:   prdata = PDATA_W'(day_level_reg);
            REG_ERROR_LIMIT: prdata = PDATA_W'(error_limit_reg);
            default:         prdata = '0;
        endcase
    end

    aldnd_ram #(
        .DATA_W (COUNT_W),
        .DEPTH  (WINDOW_SAMPLES)
    ) u_window (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg),
        .wr_data (count_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (slot_reg),
        .rd_data (ram_rd_data)
    );

    aldnd_sdiv #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (H6_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (held6),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign full      = held_reg == HELD_W'(WINDOW_SAMPLES);
    assign held6     = H6_W'({held_reg, 2'b00}) + H6_W'({held_reg, 1'b0});
    assign lhs       = CMP_W'({sum_reg, 2'b00}) + CMP_W'(sum_reg);
    assign level_sel = night_reg ? day_level_reg : night_level_reg;
    assign fail_inc  = fail_run_reg + LIMIT_W'(1);
    assign held_ext  = {{HELD_OUT_W{1'b0}}, held_reg};
    assign div_dividend = DIV_W'({sum_reg, 6'b0}) + DIV_W'({sum_reg, 4'b0});
    assign s_ready   = state_reg == ST_IDLE;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        slot_next     = slot_reg;
        held_next     = held_reg;
        sum_next      = sum_reg;
        night_next    = night_reg;
        changed_next  = changed_reg;
        request_next  = request_reg;
        fail_run_next = fail_run_reg;
        good_next     = good_reg;
        bad_next      = bad_reg;
        avg_next      = avg_reg;
        prod_next     = prod_reg;
        ram_wr_en     = 1'b0;
        ram_rd_en     = 1'b0;
        div_start     = 1'b0;
        load_out      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    count_next   = s_raw_count;
                    changed_next = 1'b0;
                    if (s_read_ok) begin
                        ram_rd_en     = 1'b1;
                        good_next     = good_reg + TOTAL_W'(1);
                        fail_run_next = '0;
                        request_next  = 1'b0;
                        state_next    = ST_SUM;
                    end else begin
                        bad_next = bad_reg + TOTAL_W'(1);
                        if (fail_inc >= error_limit_reg) begin
                            request_next  = 1'b1;
                            fail_run_next = '0;
                        end else begin
                            request_next  = 1'b0;
                            fail_run_next = fail_inc;
                        end
                        state_next = ST_OUT;
                    end
                end
            end
            ST_SUM: begin
                ram_wr_en = 1'b1;
                sum_next  = sum_reg - (full ? SUM_W'(ram_rd_data) : '0) + SUM_W'(count_reg);
                if (!full) begin
                    held_next = held_reg + HELD_W'(1);
                end
                slot_next  = (slot_reg == SLOT_W'(WINDOW_SAMPLES - 1)) ? '0
                                                                       : slot_reg + SLOT_W'(1);
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = level_sel * held6;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (night_reg) begin
                    night_next = !(lhs > prod_reg);
                end else begin
                    night_next = lhs < prod_reg;
                end
                changed_next = night_next != night_reg;
                div_start    = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    avg_next   = div_quotient[AVG_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            slot_reg     <= '0;
            held_reg     <= '0;
            sum_reg      <= '0;
            night_reg    <= 1'b0;
            fail_run_reg <= '0;
            good_reg     <= '0;
            bad_reg      <= '0;
            avg_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            held_reg     <= held_next;
            sum_reg      <= sum_next;
            night_reg    <= night_next;
            fail_run_reg <= fail_run_next;
            good_reg     <= good_next;
            bad_reg      <= bad_next;
            avg_reg      <= avg_next;
            m_valid_reg  <= m_valid_next;
        end
        count_reg   <= count_next;
        changed_reg <= changed_next;
        request_reg <= request_next;
        prod_reg    <= prod_next;
        if (load_out) begin
            m_avg_reg         <= avg_reg;
            m_night_state_reg <= night_reg;
            m_changed_reg     <= changed_reg;
            m_request_reg     <= request_reg;
            m_held_reg        <= held_ext[HELD_OUT_W-1:0];
            m_error_run_reg   <= fail_run_reg;
            m_good_reg        <= good_reg;
            m_bad_reg         <= bad_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_avg_lux_q4    = m_avg_reg;
    assign m_night_state   = m_night_state_reg;
    assign m_night_changed = m_changed_reg;
    assign m_reset_request = m_request_reg;
    assign m_samples_held  = m_held_reg;
    assign m_error_run     = m_error_run_reg;
    assign m_good_total    = m_good_reg;
    assign m_bad_total     = m_bad_reg;

    `ALDND_ASSERT(a_held_bounded, held_reg <= HELD_W'(WINDOW_SAMPLES),
        "Window fill count exceeded the window size.")
    `ALDND_ASSERT(a_run_below_max, fail_run_reg != {LIMIT_W{1'b1}},
        "Error run reached its all-ones value.")
    `ALDND_ASSERT(a_bad_poll_fast, (s_valid && s_ready && !s_read_ok) |=> state_reg == ST_OUT,
        "Failed poll did not go straight to the result stage.")
    `ALDND_ASSERT(a_div_done_in_div, div_done |-> (state_reg == ST_DIV && !div_busy),
        "Divider finished outside the divide stage.")
    `ALDND_ASSERT(a_change_not_request,
        !(m_valid_reg && m_night_changed && m_reset_request),
        "Result flags a change and a reset request together.")

endmodule
